// File: hw/rtl/rn_pkg.sv
// rn_pkg: shared types for the rational normalizer
// holds the controller state enum and the command/status structs
// no dependencies
package rn_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_DIV_N,
    ST_SWAP,
    ST_DIV_D,
    ST_DONE
  } rn_state_t;

  // which magnitude the divider works on
  typedef enum logic {
    SEL_NUMER,
    SEL_DENOM
  } rn_div_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load;
    logic        gcd_step;
    logic        gcd_fin;
    logic        div_init;
    rn_div_sel_t div_sel;
    logic        div_step;
    logic        save_qn;
    logic        out_load;
  } rn_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic special;
    logic gcd_eq;
    logic div_last;
  } rn_stat_t;

endpackage

// File: hw/rtl/rn_stream_if.sv
// rn_stream_if: valid/ready channel interfaces for the rational normalizer
// rn_in_if carries a request with the input fraction, rn_out_if the reduced one
// no dependencies
interface rn_in_if #(
  parameter int WIDTH = 32
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] numer_in;
  logic signed [WIDTH-1:0] denom_in;

  modport source (output valid, output numer_in, output denom_in, input ready);
  modport sink   (input valid, input numer_in, input denom_in, output ready);
endinterface

interface rn_out_if #(
  parameter int WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic signed [WIDTH:0] numer_out;
  logic [WIDTH-1:0]      denom_out;
  logic                  div_zero;

  modport source (output valid, output numer_out, output denom_out, output div_zero,
                  input ready);
  modport sink   (input valid, input numer_out, input denom_out, input div_zero,
                  output ready);
endinterface

// File: hw/rtl/rn_ctrl.sv
// rn_ctrl: sequencer for the rational normalizer
// steps the datapath through check, binary gcd and two serial divisions
// depends on rn_pkg
module rn_ctrl
  import rn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rn_stat_t stat,
  output rn_cmd_t  cmd
);

  rn_state_t state;
  rn_state_t state_next;
  logic      out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.div_sel    = SEL_NUMER;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.special ? ST_DONE : ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_eq) begin
          cmd.gcd_fin  = 1'b1;
          cmd.div_init = 1'b1;
          cmd.div_sel  = SEL_NUMER;
          state_next   = ST_DIV_N;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV_N: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        cmd.save_qn  = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_sel  = SEL_DENOM;
        state_next   = ST_DIV_D;
      end
      ST_DIV_D: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/rn_dpath.sv
// rn_dpath: datapath of the rational normalizer
// magnitudes, binary gcd unit, shared restoring divider and result register
// depends on rn_pkg
module rn_dpath
  import rn_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic signed [WIDTH-1:0] numer_in,
  input  logic signed [WIDTH-1:0] denom_in,
  input  rn_cmd_t                 cmd,
  output rn_stat_t                stat,
  output logic signed [WIDTH:0]   numer_out,
  output logic [WIDTH-1:0]        denom_out,
  output logic                    div_zero
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] nmag;
  logic [WIDTH-1:0] dmag;
  logic             neg;
  logic             dz;
  logic             nz;
  logic [WIDTH-1:0] ga;
  logic [WIDTH-1:0] gb;
  logic [CW-1:0]    k;
  logic [WIDTH-1:0] g;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] qn;

  logic [WIDTH-1:0] nmag_in;
  logic [WIDTH-1:0] dmag_in;
  logic [WIDTH-1:0] ga_next;
  logic [WIDTH-1:0] gb_next;
  logic             k_inc;
  logic [WIDTH:0]   sh;
  logic [WIDTH:0]   diff;
  logic [WIDTH:0]   qn_ext;

  // input magnitudes
  always_comb begin
    nmag_in = numer_in[WIDTH-1] ? WIDTH'(-numer_in) : WIDTH'(numer_in);
    dmag_in = denom_in[WIDTH-1] ? WIDTH'(-denom_in) : WIDTH'(denom_in);
  end

  // one binary gcd step
  always_comb begin
    ga_next = ga;
    gb_next = gb;
    k_inc   = 1'b0;
    if (!ga[0] && !gb[0]) begin
      ga_next = ga >> 1;
      gb_next = gb >> 1;
      k_inc   = 1'b1;
    end else if (!ga[0]) begin
      ga_next = ga >> 1;
    end else if (!gb[0]) begin
      gb_next = gb >> 1;
    end else if (ga > gb) begin
      ga_next = (ga - gb) >> 1;
    end else begin
      gb_next = (gb - ga) >> 1;
    end
  end

  // one restoring division step
  always_comb begin
    sh   = {rem, dvd[WIDTH-1]};
    diff = sh - {1'b0, g};
  end

  assign stat.special  = dz || nz;
  assign stat.gcd_eq   = (ga == gb);
  assign stat.div_last = (cnt == CW'(WIDTH - 1));

  assign qn_ext = {1'b0, qn};

  // load, gcd and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nmag <= nmag_in;
      dmag <= dmag_in;
      neg  <= numer_in[WIDTH-1] ^ denom_in[WIDTH-1];
      dz   <= (dmag_in == '0);
      nz   <= (nmag_in == '0);
      ga   <= nmag_in;
      gb   <= dmag_in;
      k    <= '0;
    end else if (cmd.gcd_step) begin
      ga <= ga_next;
      gb <= gb_next;
      if (k_inc) begin
        k <= k + 1'b1;
      end
    end
    if (cmd.gcd_fin) begin
      g <= ga << k;
    end
    if (cmd.div_init) begin
      dvd <= (cmd.div_sel == SEL_DENOM) ? dmag : nmag;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        dvd <= {dvd[WIDTH-2:0], 1'b1};
      end else begin
        rem <= sh[WIDTH-1:0];
        dvd <= {dvd[WIDTH-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.save_qn) begin
      qn <= dvd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (dz || nz) begin
        numer_out <= '0;
        denom_out <= WIDTH'(1);
        div_zero  <= dz;
      end else begin
        numer_out <= neg ? (~qn_ext) + (WIDTH+1)'(1) : qn_ext;
        denom_out <= dvd;
        div_zero  <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/rational_normalizer.sv
// rational_normalizer: top level, reduces a signed fraction to lowest terms
// joins rn_ctrl and rn_dpath to the operand and result channels
// depends on rn_pkg, rn_in_if, rn_out_if, rn_ctrl, rn_dpath
//
// usage:
//   operand channel: numer_in/denom_in, taken when valid and ready are high.
//   result channel: numer_out (WIDTH+1 bits, sign of the fraction),
//   denom_out (positive), div_zero; one result per request, in order.
//   a zero denominator gives 0/1 with div_zero set; a zero numerator 0/1.
//   one request at a time: ready is high only while the sequencer is idle.
//   from acceptance to result valid: a check state, the binary gcd loop
//   (one step a cycle until the values meet), two restoring divisions of
//   WIDTH quotient bits each sharing one divider, a swap state and a state
//   that loads the output register. zero inputs skip gcd and division.
//   the result sits in an output register, so the block returns to idle
//   and takes the next request while a result waits; a finished result
//   waits in the sequencer only when the previous one is still not taken.
//   reset (synchronous, active high) empties the output register and idles
//   the sequencer.
module rational_normalizer
  import rn_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  rn_in_if.sink   operand,
  rn_out_if.source result
);

  rn_cmd_t  cmd;
  rn_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  // sequencer
  rn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  rn_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk       (clk),
    .numer_in  (operand.numer_in),
    .denom_in  (operand.denom_in),
    .cmd       (cmd),
    .stat      (stat),
    .numer_out (result.numer_out),
    .denom_out (result.denom_out),
    .div_zero  (result.div_zero)
  );

  assign operand.ready = in_ready;
  assign result.valid  = out_valid;

endmodule
